[hdl/tgd_pkg.sv]
// types and constants shared by the tap gesture detector modules
package tgd_pkg;

   typedef enum logic [1:0] {
      PH_CLEAR      = 2'd0,
      PH_TOUCHED    = 2'd1,
      PH_REGISTERED = 2'd2,
      PH_FAILED     = 2'd3
   } phase_type;

   localparam logic [1:0] EV_POSSIBLE  = 2'd0;
   localparam logic [1:0] EV_STARTED   = 2'd1;
   localparam logic [1:0] EV_CANCELLED = 2'd2;

   localparam logic [1:0] PS_DOWN        = 2'd0;
   localparam logic [1:0] PS_UP          = 2'd1;
   localparam logic [1:0] PS_INTERRUPTED = 2'd3;

   localparam logic [1:0] CSR_MIN_TAPS     = 2'd0;
   localparam logic [1:0] CSR_MAX_TAPS     = 2'd1;
   localparam logic [1:0] CSR_MOTION_LIMIT = 2'd2;
   localparam logic [1:0] CSR_TIME_LIMIT   = 2'd3;

   localparam logic [3:0]  MIN_TAPS_RST     = 4'd1;
   localparam logic [3:0]  MAX_TAPS_RST     = 4'd2;
   localparam logic [11:0] MOTION_LIMIT_RST = 12'd20;
   localparam logic [15:0] TIME_LIMIT_RST   = 16'd500;

   typedef struct packed {
      logic [3:0]  min_taps;
      logic [3:0]  max_taps;
      logic [11:0] motion_limit;
      logic [15:0] time_limit;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  taps_seen;
      logic [11:0] anchor_x;
      logic [11:0] anchor_y;
      logic [31:0] down_ms;
      logic [31:0] last_tap_ms;
   } state_type;

   typedef struct packed {
      logic [3:0]  point_count;
      logic [1:0]  point_state;
      logic [31:0] stamp_ms;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
   } sample_type;

   typedef struct packed {
      logic        fire;
      logic [1:0]  kind;
      logic [1:0]  count;
      logic [11:0] where_x;
      logic [11:0] where_y;
      logic [31:0] ms;
   } event_type;

endpackage

[hdl/tgd_step.sv]
// next-state and event logic of the tap recognizer for one sample
module tgd_step (
   input  tgd_pkg::cfg_type    cfg,
   input  tgd_pkg::state_type  cur,
   input  tgd_pkg::sample_type smp,
   output tgd_pkg::state_type  nxt,
   output tgd_pkg::event_type  ev
);
   import tgd_pkg::*;

   function automatic logic [31:0] gap32(input logic [31:0] a, input logic [31:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic logic [11:0] gap12(input logic [11:0] a, input logic [11:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic logic in_range(input logic [1:0] taps, input cfg_type c);
      return ({2'b00, taps} >= c.min_taps) && ({2'b00, taps} <= c.max_taps);
   endfunction

   logic       moved_far;
   logic       quick_press;
   logic       gap_long;
   logic [1:0] taps_inc;

   assign moved_far   = (gap12(cur.anchor_x, smp.pos_x) > cfg.motion_limit) ||
                        (gap12(cur.anchor_y, smp.pos_y) > cfg.motion_limit);
   assign quick_press = gap32(smp.stamp_ms, cur.down_ms) < {16'd0, cfg.time_limit};
   assign gap_long    = gap32(smp.stamp_ms, cur.last_tap_ms) > {16'd0, cfg.time_limit};
   assign taps_inc    = cur.taps_seen + 2'd1;

   always_comb begin
      nxt      = cur;
      ev.fire  = 1'b0;
      ev.kind  = EV_POSSIBLE;
      ev.count = 2'd0;
      ev.ms    = smp.stamp_ms;
      if (smp.point_count != 4'd1) begin
         nxt.phase = PH_FAILED;
         ev.fire   = in_range(cur.taps_seen, cfg);
         ev.kind   = EV_STARTED;
         ev.count  = cur.taps_seen;
      end else begin
         case (cur.phase)
            PH_CLEAR: begin
               if (smp.point_state == PS_DOWN) begin
                  nxt.anchor_x    = smp.pos_x;
                  nxt.anchor_y    = smp.pos_y;
                  nxt.down_ms     = smp.stamp_ms;
                  nxt.last_tap_ms = 32'd0;
                  nxt.taps_seen   = 2'd0;
                  nxt.phase       = PH_TOUCHED;
                  ev.fire         = 1'b1;
               end
            end
            PH_TOUCHED: begin
               if (smp.point_state == PS_UP) begin
                  if (quick_press) begin
                     nxt.last_tap_ms = cur.down_ms;
                     nxt.phase       = PH_REGISTERED;
                     nxt.taps_seen   = 2'd1;
                     ev.fire         = 1'b1;
                     ev.kind         = moved_far ? EV_CANCELLED : EV_STARTED;
                     ev.count        = 2'd1;
                  end else begin
                     nxt.phase = PH_CLEAR;
                  end
               end else if (smp.point_state == PS_INTERRUPTED) begin
                  nxt.phase = PH_CLEAR;
               end
            end
            PH_REGISTERED: begin
               if (smp.point_state == PS_UP) begin
                  if (quick_press && gap_long) begin
                     nxt.last_tap_ms = smp.stamp_ms;
                     nxt.taps_seen   = 2'd1;
                     ev.fire         = 1'b1;
                     ev.kind         = moved_far ? EV_CANCELLED : EV_STARTED;
                     ev.count        = 2'd1;
                  end else if (quick_press) begin
                     nxt.taps_seen = taps_inc;
                     nxt.phase     = PH_CLEAR;
                     ev.fire       = in_range(taps_inc, cfg);
                     ev.kind       = EV_STARTED;
                     ev.count      = taps_inc;
                  end else begin
                     nxt.phase = PH_CLEAR;
                  end
               end else if (smp.point_state == PS_DOWN) begin
                  ev.fire = 1'b1;
                  if (moved_far || gap_long) begin
                     nxt.anchor_x    = smp.pos_x;
                     nxt.anchor_y    = smp.pos_y;
                     nxt.down_ms     = smp.stamp_ms;
                     nxt.last_tap_ms = 32'd0;
                     nxt.taps_seen   = 2'd0;
                     nxt.phase       = PH_TOUCHED;
                  end
               end
            end
            default: begin
               nxt.phase = PH_CLEAR;
            end
         endcase
      end
      ev.where_x = nxt.anchor_x;
      ev.where_y = nxt.anchor_y;
   end

endmodule

[hdl/tap_gesture_detector_core.sv]
// tap gesture detector top level: sample register, recognizer state and result register
//
// usage
//   req_* carries one touch sample per word (valid/ready); rsp_* carries at most one
//   gesture event per sample (valid/ready); csr_we/csr_index/csr_wdata writes the
//   min_taps, max_taps, motion_limit and time_limit registers, to be used only while
//   the block is idle.
//   an accepted sample lands in the sample register; the edge on which it advances runs
//   the recognizer once, updates its state and loads the result register, so an event
//   passes through the sample register and then the result register before it is visible.
//   throughput is one sample per cycle unless the result register stalls an event: the
//   step is one pass of compares and 12/32-bit absolute differences on both registers.
//   a sample that causes no event retires even while the result register is stalled;
//   a sample with an event waits in the sample register until the result register
//   frees, and req_ready drops only while that sample still waits.
//   synchronous reset clears the recognizer to the clear phase with zero tap count,
//   anchor and times, empties both registers and restores the register defaults.
module tap_gesture_detector_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_point_count,
   input  logic [1:0]  req_point_state,
   input  logic [31:0] req_stamp_ms,
   input  logic [11:0] req_pos_x,
   input  logic [11:0] req_pos_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [1:0]  rsp_tap_count,
   output logic [11:0] rsp_where_x,
   output logic [11:0] rsp_where_y,
   output logic [31:0] rsp_event_ms,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tgd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   sample_type smp_ff;
   logic       smp_vld_ff;
   event_type  ev;
   event_type  rsp_ff;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       advance;

   tgd_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .smp (smp_ff),
      .nxt (state_in),
      .ev  (ev)
   );

   assign advance   = smp_vld_ff && (!ev.fire || !rsp_vld_ff || rsp_ready);
   assign req_ready = !smp_vld_ff || advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MIN_TAPS:     cfg_in.min_taps     = csr_wdata[3:0];
            CSR_MAX_TAPS:     cfg_in.max_taps     = csr_wdata[3:0];
            CSR_MOTION_LIMIT: cfg_in.motion_limit = csr_wdata[11:0];
            CSR_TIME_LIMIT:   cfg_in.time_limit   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance && ev.fire) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_taps     <= MIN_TAPS_RST;
         cfg_ff.max_taps     <= MAX_TAPS_RST;
         cfg_ff.motion_limit <= MOTION_LIMIT_RST;
         cfg_ff.time_limit   <= TIME_LIMIT_RST;
         state_ff.phase       <= PH_CLEAR;
         state_ff.taps_seen   <= 2'd0;
         state_ff.anchor_x    <= 12'd0;
         state_ff.anchor_y    <= 12'd0;
         state_ff.down_ms     <= 32'd0;
         state_ff.last_tap_ms <= 32'd0;
         smp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (req_ready) begin
            smp_vld_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         smp_ff.point_count <= req_point_count;
         smp_ff.point_state <= req_point_state;
         smp_ff.stamp_ms    <= req_stamp_ms;
         smp_ff.pos_x       <= req_pos_x;
         smp_ff.pos_y       <= req_pos_y;
      end
      if (advance && ev.fire) begin
         rsp_ff <= ev;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_event_kind = rsp_ff.kind;
   assign rsp_tap_count  = rsp_ff.count;
   assign rsp_where_x    = rsp_ff.where_x;
   assign rsp_where_y    = rsp_ff.where_y;
   assign rsp_event_ms   = rsp_ff.ms;

`ifndef ASSERT_OFF
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !smp_vld_ff |-> req_ready)
      else $error("sample register empty but input not ready");

   a_possible_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_POSSIBLE) |-> (rsp_tap_count == 2'd0))
      else $error("possible event with nonzero tap count");

   a_cancel_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_CANCELLED) |-> (rsp_tap_count == 2'd1))
      else $error("cancelled event not on a single tap");

   a_multi_fails: assert property (@(posedge clock) disable iff (reset)
      advance && (smp_ff.point_count != 4'd1) |=> (state_ff.phase == PH_FAILED))
      else $error("multi-touch sample did not force failed phase");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      smp_vld_ff && !advance |=> smp_vld_ff && $stable(state_ff))
      else $error("stalled sample lost or state changed");
`endif

endmodule

[test/tb.sv]
// self-checking testbench for the tap gesture detector core
`timescale 1ns / 100ps

module tb;
   import tgd_pkg::*;

   localparam logic [1:0] PS_OTHER = 2'd2;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic       drain;
      sample_type s;
   } todo_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [1:0]  rsp_tap_count;
   logic [11:0] rsp_where_x;
   logic [11:0] rsp_where_y;
   logic [31:0] rsp_event_ms;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_wdata = 16'd0;
   sample_type  on_bus = '0;

   todo_word_type samples_todo[$];
   event_type     due_events[$];
   state_type     tracker;
   cfg_type       cfg;

   logic        req_taken = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_hold = 0;
   bit          quiet = 1'b0;
   int unsigned cycles = 0;
   int unsigned errors = 0;
   int unsigned accepted = 0;
   int unsigned delivered = 0;
   int unsigned settings = 0;

   tap_gesture_detector_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_point_count (on_bus.point_count),
      .req_point_state (on_bus.point_state),
      .req_stamp_ms    (on_bus.stamp_ms),
      .req_pos_x       (on_bus.pos_x),
      .req_pos_y       (on_bus.pos_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_tap_count   (rsp_tap_count),
      .rsp_where_x     (rsp_where_x),
      .rsp_where_y     (rsp_where_y),
      .rsp_event_ms    (rsp_event_ms),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [31:0] span(logic [31:0] a, logic [31:0] b);
      return a >= b ? a - b : b - a;
   endfunction

   function automatic bit moved_far(sample_type s);
      return span({20'd0, tracker.anchor_x}, {20'd0, s.pos_x}) > {20'd0, cfg.motion_limit} ||
             span({20'd0, tracker.anchor_y}, {20'd0, s.pos_y}) > {20'd0, cfg.motion_limit};
   endfunction

   function automatic event_type fire_event(logic [1:0] evk, logic [1:0] cnt, logic [31:0] ms);
      event_type e;
      e.fire = 1'b1;
      e.kind = evk;
      e.count = cnt;
      e.where_x = tracker.anchor_x;
      e.where_y = tracker.anchor_y;
      e.ms = ms;
      return e;
   endfunction

   function automatic event_type touch_down(sample_type s);
      tracker.anchor_x = s.pos_x;
      tracker.anchor_y = s.pos_y;
      tracker.down_ms = s.stamp_ms;
      tracker.last_tap_ms = 32'd0;
      tracker.taps_seen = 2'd0;
      tracker.phase = PH_TOUCHED;
      return fire_event(EV_POSSIBLE, 2'd0, s.stamp_ms);
   endfunction

   function automatic event_type single_tap(sample_type s);
      tracker.taps_seen = 2'd1;
      return fire_event(moved_far(s) ? EV_CANCELLED : EV_STARTED, tracker.taps_seen, s.stamp_ms);
   endfunction

   function automatic event_type ranged_report(logic [31:0] ms);
      if ({2'd0, tracker.taps_seen} >= cfg.min_taps && {2'd0, tracker.taps_seen} <= cfg.max_taps)
         return fire_event(EV_STARTED, tracker.taps_seen, ms);
      return '0;
   endfunction

   // one recognizer step; returns the event the sample causes, fire low if none
   function automatic event_type recognize(sample_type s);
      logic [31:0] lim;
      lim = {16'd0, cfg.time_limit};
      if (s.point_count != 4'd1) begin
         tracker.phase = PH_FAILED;
         return ranged_report(s.stamp_ms);
      end
      case (tracker.phase)
         PH_CLEAR: begin
            if (s.point_state == PS_DOWN)
               return touch_down(s);
         end
         PH_TOUCHED: begin
            if (s.point_state == PS_UP) begin
               if (span(s.stamp_ms, tracker.down_ms) < lim) begin
                  tracker.last_tap_ms = tracker.down_ms;
                  tracker.phase = PH_REGISTERED;
                  return single_tap(s);
               end
               tracker.phase = PH_CLEAR;
            end else if (s.point_state == PS_INTERRUPTED) begin
               tracker.phase = PH_CLEAR;
            end
         end
         PH_REGISTERED: begin
            if (s.point_state == PS_UP) begin
               if (span(s.stamp_ms, tracker.down_ms) < lim) begin
                  if (span(s.stamp_ms, tracker.last_tap_ms) > lim) begin
                     tracker.last_tap_ms = s.stamp_ms;
                     return single_tap(s);
                  end
                  tracker.taps_seen = tracker.taps_seen + 2'd1;
                  tracker.phase = PH_CLEAR;
                  return ranged_report(s.stamp_ms);
               end
               tracker.phase = PH_CLEAR;
            end else if (s.point_state == PS_DOWN) begin
               if (moved_far(s) || span(s.stamp_ms, tracker.last_tap_ms) > lim)
                  return touch_down(s);
               return fire_event(EV_POSSIBLE, 2'd0, s.stamp_ms);
            end
         end
         default: tracker.phase = PH_CLEAR;
      endcase
      return '0;
   endfunction

   function automatic int unsigned idle_len();
      int unsigned r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [11:0] nudge(logic [11:0] p, int unsigned lim);
      int unsigned s;
      int v;
      s = lim + lim / 4 + 1;
      v = int'(p) + int'($urandom_range(0, 2 * s)) - int'(s);
      if (v < 0)
         v = 0;
      if (v > 4095)
         v = 4095;
      return v[11:0];
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 40)
         $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
   endtask

   task automatic add_sample(logic [3:0] n, logic [1:0] st, logic [31:0] t,
                             logic [11:0] x, logic [11:0] y);
      todo_word_type w;
      w.drain = 1'b0;
      w.s.point_count = n;
      w.s.point_state = st;
      w.s.stamp_ms = t;
      w.s.pos_x = x;
      w.s.pos_y = y;
      samples_todo.push_back(w);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MIN_TAPS:     cfg.min_taps = val[3:0];
         CSR_MAX_TAPS:     cfg.max_taps = val[3:0];
         CSR_MOTION_LIMIT: cfg.motion_limit = val[11:0];
         CSR_TIME_LIMIT:   cfg.time_limit = val;
         default:          ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_cfg(logic [3:0] mn, logic [3:0] mx, logic [11:0] ml, logic [15:0] tl);
      write_reg(CSR_MIN_TAPS, {12'd0, mn});
      write_reg(CSR_MAX_TAPS, {12'd0, mx});
      write_reg(CSR_MOTION_LIMIT, {4'd0, ml});
      write_reg(CSR_TIME_LIMIT, tl);
      settings++;
   endtask

   // waits for every word to drain, then covers the two-stage pipeline
   task automatic idle_wait();
      while (samples_todo.size() != 0 || req_valid || due_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic gen_phase(int unsigned n);
      int unsigned tl, ml, r;
      logic [31:0] t;
      logic [11:0] x, y;
      tl = cfg.time_limit;
      ml = cfg.motion_limit;
      t = $urandom;
      x = 12'($urandom);
      y = 12'($urandom);
      while (samples_todo.size() < n) begin
         r = $urandom_range(0, 99);
         if (r < 72) begin
            // tap with random content, often close to the previous one
            if ($urandom_range(0, 3) == 0) begin
               x = 12'($urandom);
               y = 12'($urandom);
            end
            add_sample(4'd1, PS_DOWN, t, x, y);
            repeat ($urandom_range(0, 2))
               add_sample(4'd1, PS_OTHER, t + $urandom_range(0, tl), nudge(x, ml), nudge(y, ml));
            if ($urandom_range(0, 4) != 0 && tl > 0)
               t = t + $urandom_range(0, tl - 1);
            else
               t = t + $urandom_range(tl, 2 * tl + 5);
            add_sample(4'd1, $urandom_range(0, 9) == 0 ? PS_INTERRUPTED : PS_UP, t,
                       nudge(x, ml), nudge(y, ml));
            t = t + $urandom_range(0, tl + tl / 4 + 2);
         end else if (r < 86) begin
            add_sample(4'($urandom_range(0, 15)), 2'($urandom), t, 12'($urandom), 12'($urandom));
         end else begin
            t = $urandom;
            add_sample(4'($urandom), 2'($urandom), t, 12'($urandom), 12'($urandom));
         end
      end
      samples_todo[n / 2].drain = 1'b1;
   endtask

   task automatic run_phase(logic [3:0] mn, logic [3:0] mx, logic [11:0] ml, logic [15:0] tl,
                            bit q);
      set_cfg(mn, mx, ml, tl);
      quiet = q;
      gen_phase(235);
      idle_wait();
   endtask

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (samples_todo.size() != 0 &&
                      !(samples_todo[0].drain && due_events.size() != 0)) begin
            on_bus <= samples_todo[0].s;
            void'(samples_todo.pop_front());
            req_valid <= 1'b1;
            req_gap <= idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold <= idle_len();
      end
   end

   always @(posedge clock) begin
      event_type ev;
      event_type want;
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         ev = recognize(on_bus);
         if (ev.fire)
            due_events.push_back(ev);
         accepted++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         delivered++;
         if (due_events.size() == 0) begin
            report("event with none pending", {30'd0, rsp_event_kind}, 32'd0);
         end else begin
            want = due_events.pop_front();
            if (rsp_event_kind !== want.kind)
               report("event_kind", {30'd0, rsp_event_kind}, {30'd0, want.kind});
            if (rsp_tap_count !== want.count)
               report("tap_count", {30'd0, rsp_tap_count}, {30'd0, want.count});
            if (rsp_where_x !== want.where_x)
               report("where_x", {20'd0, rsp_where_x}, {20'd0, want.where_x});
            if (rsp_where_y !== want.where_y)
               report("where_y", {20'd0, rsp_where_y}, {20'd0, want.where_y});
            if (rsp_event_ms !== want.ms)
               report("event_ms", rsp_event_ms, want.ms);
         end
      end
   end

   initial begin
      tracker = '0;
      tracker.phase = PH_CLEAR;
      cfg.min_taps = MIN_TAPS_RST;
      cfg.max_taps = MAX_TAPS_RST;
      cfg.motion_limit = MOTION_LIMIT_RST;
      cfg.time_limit = TIME_LIMIT_RST;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: tap, double tap, touch count extremes, long press, wide stamps
      add_sample(4'd1, PS_DOWN, 32'd1000, 12'd100, 12'd100);
      add_sample(4'd1, PS_DOWN, 32'd1010, 12'd100, 12'd100);
      add_sample(4'd1, PS_OTHER, 32'd1020, 12'd4095, 12'd4095);
      add_sample(4'd1, PS_UP, 32'd1100, 12'd110, 12'd95);
      add_sample(4'd1, PS_OTHER, 32'd1150, 12'd0, 12'd0);
      add_sample(4'd1, PS_INTERRUPTED, 32'd1160, 12'd0, 12'd0);
      add_sample(4'd1, PS_DOWN, 32'd1200, 12'd105, 12'd105);
      add_sample(4'd1, PS_UP, 32'd1300, 12'd105, 12'd105);
      add_sample(4'd0, PS_DOWN, 32'd1400, 12'd0, 12'd0);
      add_sample(4'd15, PS_UP, 32'd1410, 12'd4095, 12'd4095);
      add_sample(4'd1, PS_DOWN, 32'd1420, 12'd7, 12'd7);
      add_sample(4'd1, PS_DOWN, 32'hFFFF_FF00, 12'd4095, 12'd0);
      add_sample(4'd1, PS_UP, 32'h0000_0010, 12'd4095, 12'd30);
      add_sample(4'd1, PS_DOWN, 32'hFFFF_FFFF, 12'd0, 12'd4095);
      add_sample(4'd1, PS_UP, 32'hFFFF_FE10, 12'd21, 12'd4095);
      add_sample(4'd1, PS_DOWN, 32'h8000_0000, 12'd2048, 12'd2048);
      add_sample(4'd1, PS_UP, 32'h8000_01F4, 12'd2048, 12'd2048);
      add_sample(4'd1, PS_INTERRUPTED, 32'h8000_0200, 12'd2048, 12'd2048);
      add_sample(4'd1, PS_DOWN, 32'd5000, 12'd2000, 12'd2000);
      add_sample(4'd1, PS_INTERRUPTED, 32'd5010, 12'd2000, 12'd2000);
      add_sample(4'd1, PS_DOWN, 32'd6000, 12'd2000, 12'd2000);
      add_sample(4'd1, PS_UP, 32'd6499, 12'd2020, 12'd1980);
      add_sample(4'd1, PS_DOWN, 32'd7100, 12'd2000, 12'd2000);
      settings++;
      idle_wait();

      // double tap outside a one-tap range
      set_cfg(4'd1, 4'd1, MOTION_LIMIT_RST, TIME_LIMIT_RST);
      quiet = 1'b1;
      add_sample(4'd1, PS_UP, 32'd7200, 12'd2000, 12'd2000);
      add_sample(4'd1, PS_DOWN, 32'd7300, 12'd2005, 12'd2000);
      add_sample(4'd1, PS_UP, 32'd7350, 12'd2005, 12'd2000);
      add_sample(4'd2, PS_OTHER, 32'd7400, 12'd2005, 12'd2000);
      samples_todo[2].drain = 1'b1;
      idle_wait();

      run_phase(MIN_TAPS_RST, MAX_TAPS_RST, MOTION_LIMIT_RST, TIME_LIMIT_RST, 1'b0);
      run_phase(4'd0, 4'd15, 12'd4095, 16'hFFFF, 1'b1);
      run_phase(4'd0, 4'd0, 12'd0, 16'd0, 1'b0);
      run_phase(4'd3, 4'd0, 12'd100, 16'd1000, 1'b0);
      run_phase(4'd15, 4'd15, 12'd4095, 16'd1, 1'b1);
      run_phase(4'($urandom_range(0, 3)), 4'($urandom_range(1, 15)),
                12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)), 1'b0);
      run_phase(4'd2, 4'd2, 12'd8, 16'd300, 1'b0);

      if (due_events.size() != 0)
         report("events never delivered", 32'd0, due_events.size());
      $display("covered %0d samples and %0d gesture events over %0d register settings",
               accepted, delivered, settings);
      $display("including multi-touch, long press, moved taps, double taps and inverted ranges");
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
